/* design/mtcp_pkg.sv */
package mtcp_pkg;

  // Number of holding registers; register address k maps to entry k-1.
  localparam int NUM_HOLD_REGS = 5;
  localparam int REG_IDX_W = (NUM_HOLD_REGS > 1) ? $clog2(NUM_HOLD_REGS) : 1;

  // Frame bytes 0..11 are kept; byte 12 (FC16 byte count) is never used.
  localparam int HDR_KEEP = 12;

  localparam logic [7:0]  FC_READ         = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0]  EXC_FLAG        = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FUNC = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'h02;
  localparam logic [7:0]  UNIT_BROADCAST  = 8'hFF;
  localparam logic [15:0] PDU_MAX         = 16'd249;

  localparam logic [7:0]  UNIT_ADDR_RESET   = 8'd1;
  localparam logic [31:0] MASTER_ADDR_RESET = 32'hC0A8_0A0A;

  typedef enum logic {
    CFG_UNIT_ADDR   = 1'b0,
    CFG_MASTER_ADDR = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE_SINGLE,
    KIND_WRITE_MULTI,
    KIND_EXCEPTION
  } resp_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  // One complete, header-checked request as handed from intake to execution.
  typedef struct packed {
    logic [HDR_KEEP-1:0][7:0]       hdr;
    logic [NUM_HOLD_REGS-1:0][15:0] stg;
    logic [31:0]                    src;
  } mtcp_cmd_t;

  function automatic logic [15:0] hr_reset_value(input int idx);
    logic [15:0] v;
    v = 16'd0;
    if (idx == 3) v = 16'd250;
    if (idx == 4) v = 16'd1013;
    return v;
  endfunction

endpackage

/* design/mtcp_front.sv */
module mtcp_front
  import mtcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  request_byte_i,
  input  logic        frame_start_i,
  input  logic [31:0] source_address_i,
  input  logic [7:0]  unit_address_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output mtcp_cmd_t   q_cmd_o
);

  logic [8:0]                     pos_q, pos_d;
  logic                           rej_q, rej_d;
  logic [HDR_KEEP-1:0][7:0]       hdr_q, hdr_d;
  logic [NUM_HOLD_REGS-1:0][15:0] stg_q, stg_d;

  logic        take;
  logic        active;
  logic [8:0]  pos_n;
  logic [8:0]  data_off;
  logic [8:0]  word_idx;
  logic [15:0] pdu_len;
  logic        hdr_ok;
  logic        done;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    pos_d    = pos_q;
    rej_d    = rej_q;
    hdr_d    = hdr_q;
    stg_d    = stg_q;
    active   = 1'b0;
    pos_n    = pos_q;
    data_off = 9'd0;
    word_idx = 9'd0;
    if (take) begin
      if (frame_start_i) begin
        pos_d = 9'd0;
        rej_d = 1'b0;
        hdr_d = '0;
        stg_d = '0;
      end
      active = !rej_d;
      if (active) begin
        data_off = pos_d - 9'd13;
        word_idx = data_off >> 1;
        if (pos_d < 9'(HDR_KEEP)) begin
          hdr_d[pos_d[3:0]] = request_byte_i;
        end else if (pos_d >= 9'd13 && word_idx < 9'(NUM_HOLD_REGS)) begin
          if (data_off[0]) begin
            stg_d[word_idx[REG_IDX_W-1:0]][7:0] = request_byte_i;
          end else begin
            stg_d[word_idx[REG_IDX_W-1:0]][15:8] = request_byte_i;
          end
        end
        pos_n = pos_d + 9'd1;
        pos_d = pos_n;
      end
    end
    pdu_len = {hdr_d[4], hdr_d[5]} - 16'd1;
    hdr_ok  = ({hdr_d[2], hdr_d[3]} == 16'd0)
           && (hdr_d[6] == unit_address_i || hdr_d[6] == UNIT_BROADCAST)
           && (pdu_len != 16'd0) && (pdu_len <= PDU_MAX);
    // Header is judged when byte 6 (unit id) has just arrived.
    done = active && (pos_n >= 9'd8) && ({7'd0, pos_n} == pdu_len + 16'd7);
    if (active && pos_n == 9'd7 && !hdr_ok) rej_d = 1'b1;
    if (done) rej_d = 1'b1;
  end

  assign q_push_o    = done;
  assign q_cmd_o.hdr = hdr_d;
  assign q_cmd_o.stg = stg_d;
  assign q_cmd_o.src = source_address_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 9'd0;
      rej_q <= 1'b0;
      hdr_q <= '0;
      stg_q <= '0;
    end else begin
      pos_q <= pos_d;
      rej_q <= rej_d;
      hdr_q <= hdr_d;
      stg_q <= stg_d;
    end
  end

endmodule

/* design/mtcp_cmd_fifo.sv */
module mtcp_cmd_fifo
  import mtcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mtcp_cmd_t push_cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output mtcp_cmd_t head_o,
  input  logic      pop_i
);

  mtcp_cmd_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

/* design/mtcp_back.sv */
module mtcp_back
  import mtcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  mtcp_cmd_t   cmd_i,
  output logic        cmd_pop_o,
  input  logic [31:0] master_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  response_byte_o,
  output logic        response_last_o,
  output logic [31:0] reads_seen_o,
  output logic [31:0] writes_done_o,
  output logic        intrusion_seen_o,
  output logic [31:0] intruder_address_o
);

  back_state_e                    state_q, state_d;
  resp_kind_e                     kind_q, kind_d;
  logic [HDR_KEEP-1:0][7:0]       hdr_q, hdr_d;
  logic [REG_IDX_W-1:0]           base_q, base_d;
  logic [7:0]                     qty2_q, qty2_d;
  logic [7:0]                     code_q, code_d;
  logic [7:0]                     exc_q, exc_d;
  logic [5:0]                     len_q, len_d;
  logic [5:0]                     idx_q, idx_d;
  logic [NUM_HOLD_REGS-1:0][15:0] hr_q, hr_d;
  logic [31:0]                    reads_q, reads_d;
  logic [31:0]                    writes_q, writes_d;
  logic                           intr_q, intr_d;
  logic [31:0]                    intr_addr_q, intr_addr_d;
  logic                           out_valid_q, out_valid_d;
  logic [7:0]                     out_byte_q;
  logic                           out_last_q;
  logic [31:0]                    out_reads_q, out_writes_q, out_intr_addr_q;
  logic                           out_intr_q;

  logic [7:0]           fc;
  logic [15:0]          first, qty;
  logic [16:0]          span;
  logic                 multi_bad, single_bad;
  logic [REG_IDX_W-1:0] base;
  logic [REG_IDX_W-1:0] off;
  logic                 note_write;
  logic                 load;
  logic [5:0]           rel;
  logic [REG_IDX_W-1:0] ridx;
  logic [15:0]          rd_word;
  logic [7:0]           reg_byte;
  logic [7:0]           byte_sel;

  assign fc    = cmd_i.hdr[7];
  assign first = {cmd_i.hdr[8], cmd_i.hdr[9]};
  assign qty   = {cmd_i.hdr[10], cmd_i.hdr[11]};
  assign span  = {1'b0, first} + {1'b0, qty};
  assign multi_bad  = (first == 16'd0) || (qty == 16'd0) || (span > 17'(NUM_HOLD_REGS + 1));
  assign single_bad = (first == 16'd0) || (first > 16'(NUM_HOLD_REGS));
  assign base  = REG_IDX_W'(first - 16'd1);

  // Response byte selection for the current index.
  assign rel      = idx_q - 6'd9;
  assign ridx     = base_q + REG_IDX_W'(rel[5:1]);
  assign rd_word  = hr_q[ridx];
  assign reg_byte = rel[0] ? rd_word[7:0] : rd_word[15:8];

  always_comb begin
    byte_sel = hdr_q[idx_q[3:0]];
    if (kind_q != KIND_WRITE_SINGLE) begin
      case (idx_q) inside
        6'd0, 6'd1, 6'd6: byte_sel = hdr_q[idx_q[3:0]];
        [6'd2:6'd4]:      byte_sel = 8'd0;
        6'd5: begin
          case (kind_q)
            KIND_READ:        byte_sel = 8'd3 + qty2_q;
            KIND_WRITE_MULTI: byte_sel = 8'd6;
            default:          byte_sel = 8'd3;
          endcase
        end
        6'd7:    byte_sel = code_q;
        6'd8: begin
          case (kind_q)
            KIND_READ:        byte_sel = qty2_q;
            KIND_WRITE_MULTI: byte_sel = hdr_q[8];
            default:          byte_sel = exc_q;
          endcase
        end
        default: byte_sel = (kind_q == KIND_READ) ? reg_byte : hdr_q[idx_q[3:0]];
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    hdr_d       = hdr_q;
    base_d      = base_q;
    qty2_d      = qty2_q;
    code_d      = code_q;
    exc_d       = exc_q;
    len_d       = len_q;
    idx_d       = idx_q;
    hr_d        = hr_q;
    reads_d     = reads_q;
    writes_d    = writes_q;
    intr_d      = intr_q;
    intr_addr_d = intr_addr_q;
    cmd_pop_o   = 1'b0;
    note_write  = 1'b0;
    load        = 1'b0;
    off         = '0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          hdr_d     = cmd_i.hdr;
          base_d    = base;
          qty2_d    = {qty[6:0], 1'b0};
          idx_d     = 6'd0;
          state_d   = BK_EMIT;
          code_d    = fc | EXC_FLAG;
          exc_d     = EXC_ILLEGAL_ADDR;
          kind_d    = KIND_EXCEPTION;
          len_d     = 6'd9;
          case (fc)
            FC_READ: begin
              reads_d = reads_q + 32'd1;
              if (!multi_bad) begin
                kind_d = KIND_READ;
                code_d = FC_READ;
                len_d  = 6'd9 + {qty[4:0], 1'b0};
              end
            end
            FC_WRITE_SINGLE: begin
              if (!single_bad) begin
                kind_d     = KIND_WRITE_SINGLE;
                len_d      = 6'd12;
                hr_d[base] = qty;
                note_write = 1'b1;
              end
            end
            FC_WRITE_MULTI: begin
              if (!multi_bad) begin
                kind_d     = KIND_WRITE_MULTI;
                code_d     = FC_WRITE_MULTI;
                len_d      = 6'd12;
                note_write = 1'b1;
                for (int i = 0; i < NUM_HOLD_REGS; i++) begin
                  off = REG_IDX_W'(i) - base;
                  if (REG_IDX_W'(i) >= base && 16'(off) < qty) hr_d[i] = cmd_i.stg[off];
                end
              end
            end
            default: exc_d = EXC_ILLEGAL_FUNC;
          endcase
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load  = 1'b1;
          idx_d = idx_q + 6'd1;
          if (idx_q == len_q - 6'd1) state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    if (note_write) begin
      writes_d = writes_q + 32'd1;
      if (cmd_i.src != master_address_i) begin
        intr_d      = 1'b1;
        intr_addr_d = cmd_i.src;
      end
    end
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= 6'd0;
      len_q       <= 6'd9;
      kind_q      <= KIND_EXCEPTION;
      reads_q     <= 32'd0;
      writes_q    <= 32'd0;
      intr_q      <= 1'b0;
      intr_addr_q <= 32'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_HOLD_REGS; i++) hr_q[i] <= hr_reset_value(i);
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      kind_q      <= kind_d;
      reads_q     <= reads_d;
      writes_q    <= writes_d;
      intr_q      <= intr_d;
      intr_addr_q <= intr_addr_d;
      out_valid_q <= out_valid_d;
      hr_q        <= hr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    base_q <= base_d;
    qty2_q <= qty2_d;
    code_q <= code_d;
    exc_q  <= exc_d;
    if (load) begin
      out_byte_q      <= byte_sel;
      out_last_q      <= (idx_q == len_q - 6'd1);
      out_reads_q     <= reads_q;
      out_writes_q    <= writes_q;
      out_intr_q      <= intr_q;
      out_intr_addr_q <= intr_addr_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign response_byte_o    = out_byte_q;
  assign response_last_o    = out_last_q;
  assign reads_seen_o       = out_reads_q;
  assign writes_done_o      = out_writes_q;
  assign intrusion_seen_o   = out_intr_q;
  assign intruder_address_o = out_intr_addr_q;

`ifndef SYNTH
  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT) |-> (idx_q < len_q))
    else $error("response index ran past the frame length");

  a_write_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT && (kind_q == KIND_WRITE_SINGLE || kind_q == KIND_WRITE_MULTI))
    |-> (len_q == 6'd12))
    else $error("write response is not twelve words long");

  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EMIT) |=> ($stable(writes_q) && $stable(reads_q) && $stable(hr_q)))
    else $error("state changed while a response was being sent");

  a_intr_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    intr_q |=> intr_q)
    else $error("intrusion flag cleared");
`endif

endmodule

/* design/modbus_tcp_holding_register_slave.sv */
// Modbus TCP holding-register server for function codes 03, 06 and 16.
// Request words enter on the in channel (valid/ready), one frame byte per
// word, with frame_start_i on the first byte of a frame and the client IPv4
// address alongside. Frames with a bad MBAP header are dropped silently.
// Each answered frame produces a response of 9 to 19 words on the out
// channel (valid/ready); response_last_o marks the final word, and every
// word carries the poll, write and intrusion status as of that request.
// Intake takes one word per cycle while in_ready_o is high. A completed
// frame is queued (two deep); its response then leaves one word per cycle
// while out_ready_i is high. The in channel stalls only while two complete
// frames wait in the queue, so a stalled receiver holds intake back after
// at most three frames. Configuration writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) take effect at the clock edge; the user must make them while
// no request is in flight, as the block does not enforce this. Reset
// restores unit id 1, the default master address, the register reset values
// and clears all counters and flags; the block is ready right after reset.
module modbus_tcp_holding_register_slave
  import mtcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  request_byte_i,
  input  logic        frame_start_i,
  input  logic [31:0] source_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  response_byte_o,
  output logic        response_last_o,
  output logic [31:0] reads_seen_o,
  output logic [31:0] writes_done_o,
  output logic        intrusion_seen_o,
  output logic [31:0] intruder_address_o
);

  logic [7:0]  unit_addr_q;
  logic [31:0] master_addr_q;

  logic      q_full, q_push, q_valid, q_pop;
  mtcp_cmd_t q_push_cmd, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_addr_q   <= UNIT_ADDR_RESET;
      master_addr_q <= MASTER_ADDR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_UNIT_ADDR:   unit_addr_q   <= cfg_data_i[7:0];
        CFG_MASTER_ADDR: master_addr_q <= cfg_data_i;
        default:         master_addr_q <= master_addr_q;
      endcase
    end
  end

  mtcp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .request_byte_i   (request_byte_i),
    .frame_start_i    (frame_start_i),
    .source_address_i (source_address_i),
    .unit_address_i   (unit_addr_q),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (q_push_cmd)
  );

  mtcp_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  mtcp_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (q_valid),
    .cmd_i              (q_head),
    .cmd_pop_o          (q_pop),
    .master_address_i   (master_addr_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .response_byte_o    (response_byte_o),
    .response_last_o    (response_last_o),
    .reads_seen_o       (reads_seen_o),
    .writes_done_o      (writes_done_o),
    .intrusion_seen_o   (intrusion_seen_o),
    .intruder_address_o (intruder_address_o)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mtcp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0]  data;
    logic        start;
    logic [31:0] src;
  } req_byte_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [31:0] reads;
    logic [31:0] writes;
    logic        intr;
    logic [31:0] intruder;
  } resp_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  cfg_reg_e    cfg_idx_i = CFG_UNIT_ADDR;
  logic [31:0] cfg_data_i = 32'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  request_byte_i = 8'd0;
  logic        frame_start_i = 1'b0;
  logic [31:0] source_address_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  response_byte_o;
  logic        response_last_o;
  logic [31:0] reads_seen_o;
  logic [31:0] writes_done_o;
  logic        intrusion_seen_o;
  logic [31:0] intruder_address_o;

  modbus_tcp_holding_register_slave dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .request_byte_i     (request_byte_i),
    .frame_start_i      (frame_start_i),
    .source_address_i   (source_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .response_byte_o    (response_byte_o),
    .response_last_o    (response_last_o),
    .reads_seen_o       (reads_seen_o),
    .writes_done_o      (writes_done_o),
    .intrusion_seen_o   (intrusion_seen_o),
    .intruder_address_o (intruder_address_o)
  );

  req_byte_t  req_backlog[$];
  resp_word_t resp_due[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;

  // Shadow copy of the server state.
  logic [7:0]  cur_unit = UNIT_ADDR_RESET;
  logic [31:0] cur_master = MASTER_ADDR_RESET;
  logic [15:0] hreg [NUM_HOLD_REGS];
  logic [7:0]  rx_hdr [13];
  logic [15:0] rx_words [NUM_HOLD_REGS];
  int          rx_pos = 0;
  logic        rx_closed = 1'b0;
  logic [31:0] poll_cnt = 32'd0;
  logic [31:0] wr_cnt = 32'd0;
  logic        intr_flag = 1'b0;
  logic [31:0] intr_addr = 32'd0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void push_response(input byte_q_t f);
    resp_word_t w;
    int k;
    for (k = 0; k < f.size(); k++) begin
      w.data = f[k];
      w.last = (k == f.size() - 1);
      w.reads = poll_cnt;
      w.writes = wr_cnt;
      w.intr = intr_flag;
      w.intruder = intr_addr;
      resp_due.push_back(w);
    end
  endfunction

  function automatic void push_exception(input logic [7:0] code, input logic [7:0] reason);
    logic [7:0] f [9];
    byte_q_t q;
    int k;
    f = '{rx_hdr[0], rx_hdr[1], 8'h00, 8'h00, 8'h00, 8'h03, rx_hdr[6], code, reason};
    for (k = 0; k < 9; k++) q.push_back(f[k]);
    push_response(q);
  endfunction

  function automatic void count_write(input logic [31:0] src);
    wr_cnt++;
    if (src != cur_master) begin
      intr_flag = 1'b1;
      intr_addr = src;
    end
  endfunction

  // Advances the shadow state by one accepted request byte and queues the
  // response words that byte completes.
  function automatic void take_request_byte(input logic [7:0] b, input logic start,
                                            input logic [31:0] src);
    byte_q_t     f;
    int          pos;
    int          w;
    int          top;
    int          k;
    logic [15:0] pdu_len;
    logic [15:0] first;
    logic [15:0] qty;
    logic [7:0]  fc;
    if (start) begin
      for (k = 0; k < 13; k++) rx_hdr[k] = 8'h00;
      for (k = 0; k < NUM_HOLD_REGS; k++) rx_words[k] = 16'h0000;
      rx_pos = 0;
      rx_closed = 1'b0;
    end
    if (rx_closed) return;
    if (rx_pos < 13) begin
      rx_hdr[rx_pos] = b;
    end else begin
      w = (rx_pos - 13) / 2;
      if (w < NUM_HOLD_REGS) begin
        if ((rx_pos - 13) % 2 == 1) rx_words[w][7:0] = b;
        else rx_words[w][15:8] = b;
      end
    end
    pos = rx_pos + 1;
    rx_pos = pos % 512;
    if (pos < 7) return;
    pdu_len = {rx_hdr[4], rx_hdr[5]} - 16'd1;
    if (pos == 7) begin
      if ({rx_hdr[2], rx_hdr[3]} != 16'd0 ||
          (rx_hdr[6] != cur_unit && rx_hdr[6] != UNIT_BROADCAST) ||
          pdu_len == 16'd0 || pdu_len > PDU_MAX) rx_closed = 1'b1;
      return;
    end
    if (pos < 7 + int'(pdu_len)) return;
    // The frame is answered; everything up to the next frame start is dropped.
    rx_closed = 1'b1;
    fc = rx_hdr[7];
    first = {rx_hdr[8], rx_hdr[9]};
    qty = {rx_hdr[10], rx_hdr[11]};
    top = int'(first) - 1 + int'(qty);
    if (fc == FC_READ) begin
      poll_cnt++;
      if (first == 16'd0 || qty == 16'd0 || top > NUM_HOLD_REGS) begin
        push_exception(FC_READ | EXC_FLAG, EXC_ILLEGAL_ADDR);
      end else begin
        f.push_back(rx_hdr[0]);
        f.push_back(rx_hdr[1]);
        f.push_back(8'h00);
        f.push_back(8'h00);
        f.push_back(8'h00);
        f.push_back(8'(3 + 2 * int'(qty)));
        f.push_back(rx_hdr[6]);
        f.push_back(FC_READ);
        f.push_back(8'(2 * int'(qty)));
        for (k = 0; k < int'(qty); k++) begin
          f.push_back(hreg[int'(first) - 1 + k][15:8]);
          f.push_back(hreg[int'(first) - 1 + k][7:0]);
        end
        push_response(f);
      end
    end else if (fc == FC_WRITE_SINGLE) begin
      if (first == 16'd0 || first > NUM_HOLD_REGS) begin
        push_exception(FC_WRITE_SINGLE | EXC_FLAG, EXC_ILLEGAL_ADDR);
      end else begin
        hreg[int'(first) - 1] = qty;
        count_write(src);
        for (k = 0; k < 12; k++) f.push_back(rx_hdr[k]);
        push_response(f);
      end
    end else if (fc == FC_WRITE_MULTI) begin
      if (first == 16'd0 || qty == 16'd0 || top > NUM_HOLD_REGS) begin
        push_exception(FC_WRITE_MULTI | EXC_FLAG, EXC_ILLEGAL_ADDR);
      end else begin
        for (k = 0; k < int'(qty); k++) hreg[int'(first) - 1 + k] = rx_words[k];
        count_write(src);
        f.push_back(rx_hdr[0]);
        f.push_back(rx_hdr[1]);
        f.push_back(8'h00);
        f.push_back(8'h00);
        f.push_back(8'h00);
        f.push_back(8'h06);
        f.push_back(rx_hdr[6]);
        f.push_back(FC_WRITE_MULTI);
        for (k = 8; k < 12; k++) f.push_back(rx_hdr[k]);
        push_response(f);
      end
    end else begin
      push_exception(fc | EXC_FLAG, EXC_ILLEGAL_FUNC);
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    req_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        take_request_byte(request_byte_i, frame_start_i, source_address_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          in_valid_i <= 1'b1;
          request_byte_i <= nxt.data;
          frame_start_i <= nxt.start;
          source_address_i <= nxt.src;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_responses
    resp_word_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (resp_due.size() == 0) begin
          $display("%0t: unexpected response word, expected none, actual %h",
                   $time, response_byte_o);
          mismatches++;
        end else begin
          want = resp_due.pop_front();
          check_field("response_byte", want.data, response_byte_o);
          check_field("response_last", want.last, response_last_o);
          check_field("reads_seen", want.reads, reads_seen_o);
          check_field("writes_done", want.writes, writes_done_o);
          check_field("intrusion_seen", want.intr, intrusion_seen_o);
          check_field("intruder_address", want.intruder, intruder_address_o);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic int data_words(input logic [15:0] qty);
    return (qty > 16'd8) ? 8 : int'(qty);
  endfunction

  // PDU bytes: function code, first address, quantity or value, and for
  // multiple writes a byte count followed by random data words.
  function automatic byte_q_t make_pdu(input logic [7:0] fc, input logic [15:0] first,
                                       input logic [15:0] qty, input int n_data);
    byte_q_t p;
    int k;
    p.push_back(fc);
    p.push_back(first[15:8]);
    p.push_back(first[7:0]);
    p.push_back(qty[15:8]);
    p.push_back(qty[7:0]);
    if (n_data >= 0) begin
      p.push_back(8'(2 * n_data));
      for (k = 0; k < 2 * n_data; k++) p.push_back(8'($urandom()));
    end
    return p;
  endfunction

  // Queues an MBAP header plus PDU. A negative length uses PDU size plus one;
  // a cut sends only that many leading bytes.
  function automatic int queue_frame(input byte_q_t pdu, input logic [7:0] unit,
                                     input logic [15:0] proto, input int len_field,
                                     input int cut, input logic with_start,
                                     input logic [31:0] src);
    byte_q_t     fr;
    req_byte_t   it;
    logic [15:0] len;
    logic [15:0] tid;
    logic        scramble;
    int          n;
    int          k;
    len = (len_field < 0) ? 16'(pdu.size() + 1) : 16'(len_field);
    tid = 16'($urandom());
    fr.push_back(tid[15:8]);
    fr.push_back(tid[7:0]);
    fr.push_back(proto[15:8]);
    fr.push_back(proto[7:0]);
    fr.push_back(len[15:8]);
    fr.push_back(len[7:0]);
    fr.push_back(unit);
    for (k = 0; k < pdu.size(); k++) fr.push_back(pdu[k]);
    n = (cut < 0 || cut > fr.size()) ? fr.size() : cut;
    // Only the final byte's source address counts, so earlier ones may vary.
    scramble = ($urandom_range(3) == 0);
    for (k = 0; k < n; k++) begin
      it.data = fr[k];
      it.start = with_start && (k == 0);
      it.src = (k == n - 1 || !scramble) ? src : $urandom();
      req_backlog.push_back(it);
    end
    return n;
  endfunction

  function automatic void queue_request(input logic [7:0] fc, input logic [15:0] first,
                                        input logic [15:0] qty, input logic [31:0] src);
    void'(queue_frame(make_pdu(fc, first, qty,
                               (fc == FC_WRITE_MULTI) ? data_words(qty) : -1),
                      cur_unit, 16'd0, -1, -1, 1'b1, src));
  endfunction

  function automatic int queue_random_frame();
    logic [7:0]  fc;
    logic [7:0]  unit;
    logic [15:0] first;
    logic [15:0] qty;
    logic [31:0] src;
    byte_q_t     pdu;
    int          kind;
    int          n;
    case ($urandom_range(2))
      0: fc = FC_READ;
      1: fc = FC_WRITE_SINGLE;
      default: fc = FC_WRITE_MULTI;
    endcase
    kind = $urandom_range(99);
    if (kind < 8) fc = 8'($urandom());
    first = 16'($urandom_range(1, NUM_HOLD_REGS));
    qty = 16'($urandom_range(1, NUM_HOLD_REGS + 1 - int'(first)));
    if (fc == FC_WRITE_SINGLE) qty = 16'($urandom());
    if ($urandom_range(9) == 0) first = 16'($urandom_range(0, NUM_HOLD_REGS + 1));
    if ($urandom_range(9) == 0) qty = 16'($urandom_range(0, NUM_HOLD_REGS + 1));
    if ($urandom_range(24) == 0) first = 16'($urandom());
    if ($urandom_range(24) == 0) qty = 16'($urandom());
    unit = ($urandom_range(4) == 0) ? UNIT_BROADCAST : cur_unit;
    src = ($urandom_range(2) == 0) ? $urandom() : cur_master;
    pdu = make_pdu(fc, first, qty, (fc == FC_WRITE_MULTI) ? data_words(qty) : -1);
    if (kind >= 8 && kind < 16) begin
      case ($urandom_range(2))
        0: n = queue_frame(pdu, unit, 16'($urandom_range(1, 65535)), -1, -1, 1'b1, src);
        1: n = queue_frame(pdu, 8'($urandom()), 16'd0, -1, -1, 1'b1, src);
        default: n = queue_frame(pdu, unit, 16'd0, int'($urandom_range(0, 65535)), -1,
                                 1'b1, src);
      endcase
    end else if (kind < 26) begin
      n = queue_frame(pdu, unit, 16'd0, -1, int'($urandom_range(1, 6 + pdu.size())),
                      1'b1, src);
    end else if (kind < 32) begin
      // Short length field: missing PDU bytes read as zero, the rest is dropped.
      n = queue_frame(pdu, unit, 16'd0, int'($urandom_range(2, 5)), -1, 1'b1, src);
    end else begin
      n = queue_frame(pdu, unit, 16'd0, -1, -1, 1'b1, src);
    end
    return n;
  endfunction

  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid_i || resp_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_config(input cfg_reg_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_UNIT_ADDR) cur_unit = value[7:0];
    else cur_master = value;
  endtask

  task automatic run_phase(input logic [7:0] unit, input logic [31:0] master,
                           input int in_idle, input int out_stall, input int n_bytes,
                           input logic pause_midway);
    int queued;
    write_config(CFG_UNIT_ADDR, {24'd0, unit});
    write_config(CFG_MASTER_ADDR, master);
    send_idle_pct = in_idle;
    recv_stall_pct = out_stall;
    queued = 0;
    while (queued < n_bytes / 2) queued += queue_random_frame();
    if (pause_midway) wait_drained();
    while (queued < n_bytes) queued += queue_random_frame();
    wait_drained();
  endtask

  initial begin : stimulus
    int k;
    for (k = 0; k < NUM_HOLD_REGS; k++) begin
      hreg[k] = (k == 3) ? 16'd250 : (k == 4) ? 16'd1013 : 16'd0;
    end
    for (k = 0; k < 13; k++) rx_hdr[k] = 8'h00;
    for (k = 0; k < NUM_HOLD_REGS; k++) rx_words[k] = 16'h0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The very first frame after reset comes without a frame start.
    void'(queue_frame(make_pdu(FC_READ, 16'd4, 16'd2, -1), cur_unit, 16'd0, -1, -1, 1'b0,
                      cur_master));
    queue_request(FC_WRITE_SINGLE, 16'd1, 16'h0000, 32'h0000_0000);
    // Data beyond the register file is not kept; byte count is never checked.
    void'(queue_frame(make_pdu(FC_WRITE_MULTI, 16'd2, 16'd3, 6), cur_unit, 16'd0, -1, -1,
                      1'b1, cur_master));
    queue_request(FC_READ, 16'd1, 16'd5, cur_master);
    queue_request(FC_WRITE_SINGLE, 16'd6, 16'h1234, cur_master);
    void'(queue_frame(make_pdu(FC_READ, 16'd1, 16'd1, -1), 8'd2, 16'd0, -1, -1, 1'b1,
                      cur_master));
    // Bytes after an answered frame without a new frame start are ignored.
    queue_request(FC_READ, 16'd1, 16'd1, cur_master);
    void'(queue_frame(make_pdu(FC_READ, 16'd1, 16'd1, -1), cur_unit, 16'd0, -1, -1, 1'b0,
                      cur_master));
    wait_drained();

    run_phase(8'h00, 32'h0000_0000, 0, 0, 16, 1'b0);
    run_phase(8'hFF, 32'hFFFF_FFFF, 86, 0, 16, 1'b0);
    run_phase(8'($urandom()), $urandom(), 0, 86, 16, 1'b1);
    run_phase(UNIT_ADDR_RESET, MASTER_ADDR_RESET, 33, 33, 16, 1'b0);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
